>>> sv/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Types, widths and constants shared by the heading PID controller modules.
// ----------------------------------------------------------------------------
package hpid_pkg;

    // item field widths
    localparam int ANGLE_W    = 9;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 32;
    localparam int IN_DATA_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd3277;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd410;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd205;

    // internal datapath widths
    localparam int ERR_W      = 10;
    localparam int DIFF_W     = 11;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int Q_FRAC     = 12;
    localparam int QT_W       = PROD_W - Q_FRAC;
    localparam int P_W        = 14;
    localparam int D_W        = 15;
    localparam int DIVD_W     = 14;
    localparam int ACC_W      = 33;
    localparam int SUM_W      = 38;

    localparam int DIV_CNT_W  = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(DIVD_W - 1);

    localparam logic signed [ERR_W-1:0] HALF_TURN     = 10'sd180;
    localparam logic signed [ERR_W-1:0] NEG_HALF_TURN = -10'sd180;
    localparam logic signed [ERR_W-1:0] FULL_TURN     = 10'sd360;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_INT,
        S_ACC_INT,
        S_MUL_P,
        S_TAKE_P,
        S_MUL_I,
        S_TAKE_I,
        S_MUL_D,
        S_TAKE_D,
        S_DIV,
        S_SUM
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL,
        DP_ACC_INT,
        DP_TAKE_P,
        DP_TAKE_I,
        DP_TAKE_D,
        DP_DIV_STEP,
        DP_SUM
    } dp_op_t;

    typedef enum logic [1:0] {
        MUL_DT_ERR,
        MUL_GP_ERR,
        MUL_GI_INT,
        MUL_GD_DIFF
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic dt_zero;
    } dp_status_t;

endpackage

>>> sv/hpid_ctrl.sv
// ----------------------------------------------------------------------------
// hpid_ctrl
// Sequencer: steps one item through multiply, integrate, divide and sum.
// ----------------------------------------------------------------------------
module hpid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hpid_pkg::dp_status_t status,
    output hpid_pkg::dp_cmd_t    cmd
);
    import hpid_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL_INT;
            end
            S_MUL_INT: state_next = S_ACC_INT;
            S_ACC_INT: state_next = S_MUL_P;
            S_MUL_P:   state_next = S_TAKE_P;
            S_TAKE_P:  state_next = S_MUL_I;
            S_MUL_I:   state_next = S_TAKE_I;
            S_TAKE_I:  state_next = S_MUL_D;
            S_MUL_D:   state_next = S_TAKE_D;
            S_TAKE_D:
            begin
                // skip the divider when the derivative is forced to zero
                state_next = status.dt_zero ? S_SUM : S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_SUM;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end
            S_SUM:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.op      = DP_NONE;
        cmd.mul_sel = MUL_DT_ERR;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = DP_LOAD;
            end
            S_MUL_INT:
            begin
                cmd.op      = DP_MUL;
                cmd.mul_sel = MUL_DT_ERR;
            end
            S_ACC_INT: cmd.op = DP_ACC_INT;
            S_MUL_P:
            begin
                cmd.op      = DP_MUL;
                cmd.mul_sel = MUL_GP_ERR;
            end
            S_TAKE_P:  cmd.op = DP_TAKE_P;
            S_MUL_I:
            begin
                cmd.op      = DP_MUL;
                cmd.mul_sel = MUL_GI_INT;
            end
            S_TAKE_I:  cmd.op = DP_TAKE_I;
            S_MUL_D:
            begin
                cmd.op      = DP_MUL;
                cmd.mul_sel = MUL_GD_DIFF;
            end
            S_TAKE_D:  cmd.op = DP_TAKE_D;
            S_DIV:     cmd.op = DP_DIV_STEP;
            S_SUM:
            begin
                if (status.out_free)
                    cmd.op = DP_SUM;
            end
            default:   cmd.op = DP_NONE;
        endcase
    end

`ifndef SYNTH
    a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("divider step count out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL_INT) && !in_ready)
        else $error("accepted item did not start the sequence");
`endif

endmodule

>>> sv/hpid_datapath.sv
// ----------------------------------------------------------------------------
// hpid_datapath
// Gains, PID state, shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module hpid_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [hpid_pkg::GAIN_W-1:0]             cfg_data,
    input  logic signed [hpid_pkg::ANGLE_W-1:0]     in_angle,
    input  logic                                    in_camera,
    input  logic [hpid_pkg::DT_W-1:0]               in_dt,
    input  hpid_pkg::dp_cmd_t                       cmd,
    output hpid_pkg::dp_status_t                    status,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [hpid_pkg::OUT_W-1:0]              out_drive,
    output logic                                    out_sat
);
    import hpid_pkg::*;

    // truncate toward zero after dropping the Q4.12 fraction
    function automatic logic signed [QT_W-1:0] q_trunc(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] b;
        b = v + (v[PROD_W-1] ? PROD_W'((1 << Q_FRAC) - 1) : PROD_W'(0));
        return b[PROD_W-1:Q_FRAC];
    endfunction

    logic [GAIN_W-1:0]          gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [OUT_W-1:0]    integ_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [DT_W-1:0]            dt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [P_W-1:0]      p_reg;
    logic signed [QT_W-1:0]     i_reg;
    logic [DIVD_W-1:0]          divd_reg;
    logic [DT_W-1:0]            rem_reg;
    logic                       d_neg_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;
    logic [OUT_W-1:0]           out_drive_reg;
    logic                       out_sat_reg;

    logic signed [ERR_W-1:0]    err_raw, err_wrap;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [ACC_W-1:0]    acc;
    logic                       acc_ovf;
    logic signed [OUT_W-1:0]    acc_sat;
    logic signed [PROD_W-1:0]   prod_mag;
    logic [DT_W+1:0]            trial;
    logic signed [D_W-1:0]      d_val;
    logic signed [SUM_W-1:0]    sum;
    logic                       sum_ovf;
    logic [OUT_W-1:0]           sum_sat;

    // error against a zero target, wrapped once unless in camera mode
    always_comb
    begin
        err_raw  = ERR_W'(0) - ERR_W'(in_angle);
        err_wrap = err_raw;
        if (!in_camera)
        begin
            if (err_raw > HALF_TURN)
                err_wrap = err_raw - FULL_TURN;
            else if (err_raw < NEG_HALF_TURN)
                err_wrap = err_raw + FULL_TURN;
        end
    end

    assign diff = DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DT_ERR:
            begin
                mul_a = {1'b0, dt_reg};
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_GP_ERR:
            begin
                mul_a = {1'b0, gain_p_reg};
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_GI_INT:
            begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = integ_reg;
            end
            MUL_GD_DIFF:
            begin
                mul_a = {1'b0, gain_d_reg};
                mul_b = MUL_B_W'(diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // saturating integral update
    always_comb
    begin
        acc     = ACC_W'(integ_reg) + prod_reg[ACC_W-1:0];
        acc_ovf = acc[ACC_W-1] != acc[ACC_W-2];
        if (acc_ovf)
            acc_sat = acc[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            acc_sat = acc[OUT_W-1:0];
    end

    assign prod_mag = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    // one restoring division step: shift in the next dividend bit
    assign trial = {1'b0, rem_reg, divd_reg[DIVD_W-1]} - {2'b00, dt_reg};

    // final sum with output clamp
    always_comb
    begin
        if (dt_reg == '0)
            d_val = '0;
        else if (d_neg_reg)
            d_val = -D_W'(divd_reg);
        else
            d_val = D_W'(divd_reg);
        sum     = SUM_W'(p_reg) + SUM_W'(i_reg) + SUM_W'(d_val);
        sum_ovf = (sum[SUM_W-1:OUT_W-1] != '0) && (sum[SUM_W-1:OUT_W-1] != '1);
        if (sum_ovf)
            sum_sat = sum[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            sum_sat = sum[OUT_W-1:0];
    end

    // configuration, PID state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN_P: gain_p_reg <= cfg_data;
                    CFG_GAIN_I: gain_i_reg <= cfg_data;
                    CFG_GAIN_D: gain_d_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.op == DP_ACC_INT)
                integ_reg <= acc_sat;
            if (cmd.op == DP_SUM)
            begin
                prev_err_reg  <= err_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                err_reg <= err_wrap;
                dt_reg  <= in_dt;
            end
            DP_MUL:     prod_reg <= prod_full;
            DP_ACC_INT: hit_reg  <= acc_ovf;
            DP_TAKE_P:  p_reg    <= P_W'(q_trunc(prod_reg));
            DP_TAKE_I:  i_reg    <= q_trunc(prod_reg);
            DP_TAKE_D:
            begin
                divd_reg  <= prod_mag[Q_FRAC +: DIVD_W];
                rem_reg   <= '0;
                d_neg_reg <= prod_reg[PROD_W-1];
            end
            DP_DIV_STEP:
            begin
                if (trial[DT_W+1])
                    rem_reg <= {rem_reg[DT_W-2:0], divd_reg[DIVD_W-1]};
                else
                    rem_reg <= trial[DT_W-1:0];
                divd_reg <= {divd_reg[DIVD_W-2:0], ~trial[DT_W+1]};
            end
            DP_SUM:
            begin
                out_drive_reg <= sum_sat;
                out_sat_reg   <= hit_reg | sum_ovf;
            end
            default: ;
        endcase
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.dt_zero  = (dt_reg == '0);
    assign out_valid       = out_valid_reg;
    assign out_drive       = out_drive_reg;
    assign out_sat         = out_sat_reg;

`ifndef SYNTH
    a_sum_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_SUM) |-> (!out_valid_reg || out_ready))
        else $error("result written over an unread result");

    a_zero_dt_holds_integral: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_ACC_INT && dt_reg == '0) |=> (integ_reg == $past(integ_reg)))
        else $error("integral moved with zero elapsed time");
`endif

endmodule

>>> sv/heading_pid_with_angle_wrap.sv
// ----------------------------------------------------------------------------
// heading_pid_with_angle_wrap
// Heading PID controller with angle wrap, stream in and stream out.
// ----------------------------------------------------------------------------
// After an item is accepted the sequencer runs the integral update, the
// P, I and D products, the divider and the sum that raises m_tvalid; the
// divider is skipped at zero elapsed_ms. No new item is taken before the sum;
// the 14-step restoring divider for the derivative term is the longest part.
// A finished result waits in the output register while the next item runs.
// Reset: gains return to 3277/410/205, integral and previous error clear.
// ----------------------------------------------------------------------------
module heading_pid_with_angle_wrap (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hpid_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hpid_pkg::IN_DATA_W-1:0]      s_tdata,   // measured_angle[8:0], elapsed_ms[24:9]
    input  logic                                s_tuser,   // camera_mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hpid_pkg::OUT_W-1:0]          m_tdata,   // drive_value[31:0]
    output logic                                m_tuser    // saturated
);
    import hpid_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hpid_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_angle  (s_tdata[ANGLE_W-1:0]),
        .in_camera (s_tuser),
        .in_dt     (s_tdata[ANGLE_W +: DT_W]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (m_tdata),
        .out_sat   (m_tuser)
    );

endmodule
